// ===== src/bclpd_pkg.sv =====
// Shared types and codes for the button click and long-press detector.
package bclpd_pkg;

    // Widths of the configuration registers and result fields.
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned THRESH_W    = 16;
    localparam int unsigned BUTTON_W    = 4;
    localparam int unsigned CLICKS_W    = 8;

    // Reset values of the configuration registers.
    localparam logic                RST_PRESS_LEVEL = 1'b1;
    localparam logic [THRESH_W-1:0] RST_LONG_TICKS  = 16'd1000;
    localparam logic [THRESH_W-1:0] RST_GAP_TICKS   = 16'd250;
    localparam logic [BUTTON_W-1:0] RST_BUTTON      = 4'd0;

    // Click count saturation limit.
    localparam logic [CLICKS_W-1:0] CLICKS_MAX = 8'd255;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRESS_LEVEL = 2'd0,
        CFG_LONG_TICKS  = 2'd1,
        CFG_GAP_TICKS   = 2'd2,
        CFG_BUTTON      = 2'd3
    } t_cfg_index;

    // Window classification after the majority votes.
    typedef enum logic [1:0] {
        CLASS_LOW  = 2'd0,
        CLASS_HIGH = 2'd1,
        CLASS_FALL = 2'd2,
        CLASS_RISE = 2'd3
    } t_level_class;

    // Reported gesture kinds.
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_CLICK  = 3'd1,
        KIND_DOUBLE = 3'd2,
        KIND_MULTI  = 3'd3,
        KIND_LONG   = 3'd4
    } t_event_kind;

    // Transition seen in this tick.
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PRESS   = 2'd1,
        ACT_RELEASE = 2'd2
    } t_action;

    // Configuration register contents.
    typedef struct packed {
        logic                press_level;
        logic [THRESH_W-1:0] long_ticks;
        logic [THRESH_W-1:0] gap_ticks;
        logic [BUTTON_W-1:0] button;
    } t_cfg;

    // Window classifier to gesture tracker.
    typedef struct packed {
        t_level_class level;
        logic         prev_on;
        logic         now_on;
    } t_level_info;

    // Gesture tracker outcome for one tick.
    typedef struct packed {
        t_event_kind         kind;
        logic [CLICKS_W-1:0] clicks;
        t_action             action;
    } t_gesture;

    // One result transaction.
    typedef struct packed {
        logic                event_valid;
        t_event_kind         kind;
        logic [CLICKS_W-1:0] clicks;
        logic [BUTTON_W-1:0] button;
        t_level_class        level;
        t_action             action;
    } t_result;

endpackage

// ===== src/bclpd_cfg.sv =====
// Configuration registers of the button detector.
module bclpd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bclpd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bclpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output bclpd_pkg::t_cfg                     o_cfg
);
    import bclpd_pkg::*;

    t_cfg r_cfg;

    // Register writes, each keeps only its own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_level <= RST_PRESS_LEVEL;
            r_cfg.long_ticks  <= RST_LONG_TICKS;
            r_cfg.gap_ticks   <= RST_GAP_TICKS;
            r_cfg.button      <= RST_BUTTON;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PRESS_LEVEL: r_cfg.press_level <= i_cfg_data[0];
                CFG_LONG_TICKS:  r_cfg.long_ticks  <= i_cfg_data[THRESH_W-1:0];
                CFG_GAP_TICKS:   r_cfg.gap_ticks   <= i_cfg_data[THRESH_W-1:0];
                CFG_BUTTON:      r_cfg.button      <= i_cfg_data[BUTTON_W-1:0];
                default:         r_cfg.button      <= r_cfg.button;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/bclpd_window.sv =====
// Sample window with majority votes over its older and newer halves.
module bclpd_window #(
    parameter int unsigned WINDOW_LENGTH = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_pin_level,
    input  logic                    i_press_level,
    output bclpd_pkg::t_level_info  o_info
);
    import bclpd_pkg::*;

    localparam int unsigned N_OLD = WINDOW_LENGTH / 2;
    localparam int unsigned N_NEW = WINDOW_LENGTH - N_OLD;
    localparam int unsigned CNT_W = $clog2(WINDOW_LENGTH + 1);
    localparam logic [CNT_W-1:0] VOTE_OLD = CNT_W'((N_OLD + 1) / 2);
    localparam logic [CNT_W-1:0] VOTE_NEW = CNT_W'((N_NEW + 1) / 2);

    // Bit 0 is the oldest sample, the top bit the newest.
    logic [WINDOW_LENGTH-1:0] r_window;
    logic [WINDOW_LENGTH-1:0] n_window;
    t_level_class             r_class;
    t_level_class             n_class;
    logic [CNT_W-1:0]         ones_old;
    logic [CNT_W-1:0]         ones_new;
    logic                     vote_old;
    logic                     vote_new;

    // Shift in the pressed flag of this sample.
    assign n_window = {(i_pin_level == i_press_level), r_window[WINDOW_LENGTH-1:1]};

    // Population counts of both halves.
    always_comb begin
        ones_old = '0;
        ones_new = '0;
        for (int i = 0; i < N_OLD; i++) begin
            ones_old = ones_old + CNT_W'(n_window[i]);
        end
        for (int i = N_OLD; i < WINDOW_LENGTH; i++) begin
            ones_new = ones_new + CNT_W'(n_window[i]);
        end
    end

    assign vote_old = (ones_old >= VOTE_OLD);
    assign vote_new = (ones_new >= VOTE_NEW);

    // Classify the window from the two votes.
    always_comb begin
        unique case ({vote_old, vote_new})
            2'b00:   n_class = CLASS_LOW;
            2'b11:   n_class = CLASS_HIGH;
            2'b10:   n_class = CLASS_FALL;
            default: n_class = CLASS_RISE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_class  <= CLASS_LOW;
        end else if (i_accept) begin
            r_window <= n_window;
            r_class  <= n_class;
        end
    end

    // High and rising edge both count as pressed.
    assign o_info.level   = n_class;
    assign o_info.prev_on = (r_class == CLASS_HIGH) || (r_class == CLASS_RISE);
    assign o_info.now_on  = (n_class == CLASS_HIGH) || (n_class == CLASS_RISE);

endmodule

// ===== src/bclpd_gesture.sv =====
// Hold and gap timing with click, multi-click and long-press reporting.
module bclpd_gesture #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  bclpd_pkg::t_level_info  i_info,
    input  bclpd_pkg::t_cfg         i_cfg,
    output bclpd_pkg::t_gesture     o_gesture
);
    import bclpd_pkg::*;

    localparam int unsigned CMP_W = (COUNTER_WIDTH > THRESH_W) ? COUNTER_WIDTH : THRESH_W;

    logic                     r_held,  n_held;
    logic [COUNTER_WIDTH-1:0] r_hold,  n_hold;
    logic [COUNTER_WIDTH-1:0] r_gap,   n_gap;
    logic [CLICKS_W-1:0]      r_tally, n_tally;
    logic                     r_long,  n_long;
    logic                     r_await, n_await;
    t_gesture                 gest;

    // Next state and the event of this tick.
    always_comb begin
        logic ended_long;
        ended_long = 1'b0;
        n_held     = r_held;
        n_hold     = r_hold;
        n_gap      = r_gap;
        n_tally    = r_tally;
        n_long     = r_long;
        n_await    = r_await;
        gest.kind   = KIND_NONE;
        gest.clicks = '0;
        gest.action = ACT_NONE;

        // Press and release transitions.
        if (!i_info.prev_on && i_info.now_on) begin
            gest.action = ACT_PRESS;
            n_held  = 1'b1;
            n_hold  = '0;
            n_gap   = '0;
            n_long  = 1'b0;
            n_await = 1'b0;
        end else if (i_info.prev_on && !i_info.now_on && r_held) begin
            n_held = 1'b0;
            if (r_long) begin
                // A release after a long press drops the whole sequence silently.
                ended_long = 1'b1;
                n_tally = '0;
                n_hold  = '0;
                n_gap   = '0;
                n_long  = 1'b0;
                n_await = 1'b0;
            end else begin
                gest.action = ACT_RELEASE;
                if (r_tally != CLICKS_MAX) begin
                    n_tally = r_tally + CLICKS_W'(1);
                end
                n_hold  = '0;
                n_gap   = '0;
                n_await = 1'b1;
            end
        end

        // Hold timing while pressed, gap timing while waiting for more clicks.
        if (!ended_long) begin
            if (n_held) begin
                if (n_hold != '1) begin
                    n_hold = n_hold + COUNTER_WIDTH'(1);
                end
                if (!n_long && (CMP_W'(n_hold) >= CMP_W'(i_cfg.long_ticks))) begin
                    n_long    = 1'b1;
                    n_tally   = '0;
                    n_gap     = '0;
                    n_await   = 1'b0;
                    gest.kind = KIND_LONG;
                end
            end else if (n_await) begin
                if (n_gap != '1) begin
                    n_gap = n_gap + COUNTER_WIDTH'(1);
                end
                if (CMP_W'(n_gap) >= CMP_W'(i_cfg.gap_ticks)) begin
                    gest.clicks = n_tally;
                    priority if (n_tally == CLICKS_W'(2)) begin
                        gest.kind = KIND_DOUBLE;
                    end else if (n_tally > CLICKS_W'(2)) begin
                        gest.kind = KIND_MULTI;
                    end else begin
                        gest.kind = KIND_CLICK;
                    end
                    gest.action = ACT_NONE;
                    n_tally = '0;
                    n_hold  = '0;
                    n_gap   = '0;
                    n_long  = 1'b0;
                    n_await = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_hold  <= '0;
            r_gap   <= '0;
            r_tally <= '0;
            r_long  <= 1'b0;
            r_await <= 1'b0;
        end else if (i_accept) begin
            r_held  <= n_held;
            r_hold  <= n_hold;
            r_gap   <= n_gap;
            r_tally <= n_tally;
            r_long  <= n_long;
            r_await <= n_await;
        end
    end

    assign o_gesture = gest;

endmodule

// ===== src/button_click_long_press_detector.sv =====
// Top level of the button debounce, click and long-press detector.
//
//   channel   direction  handshake                 payload
//   ------    ---------  ------------------------  -------------------------------------
//   sample    in         i_in_valid / o_in_stall   i_pin_level
//   event     out        o_out_valid / i_out_stall o_event_valid .. o_action_now
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// Every sample transaction yields exactly one registered result transaction.
// One sample can be taken every cycle while o_in_stall is low; the window update and
// the counter update are combinational logic ahead of the output register.
// A two-entry output stage (output register plus skid register) lets the input keep
// flowing after the output stalls until the skid is full, which o_in_stall flags.
// Reset is synchronous and active low; it clears the window, the gesture state,
// the output stage and loads the configuration defaults.
module button_click_long_press_detector #(
    parameter int unsigned WINDOW_LENGTH = 10,
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bclpd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bclpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_pin_level,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_event_valid,
    output logic [2:0]                          o_event_kind,
    output logic [bclpd_pkg::CLICKS_W-1:0]      o_clicks_reported,
    output logic [bclpd_pkg::BUTTON_W-1:0]      o_button_echo,
    output logic [1:0]                          o_level_class,
    output logic [1:0]                          o_action_now
);
    import bclpd_pkg::*;

    t_cfg        cfg;
    t_level_info info;
    t_gesture    gest;
    t_result     result;
    logic        accept;
    logic        out_free;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    assign accept   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    bclpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bclpd_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pin_level   (i_pin_level),
        .i_press_level (cfg.press_level),
        .o_info        (info)
    );

    bclpd_gesture #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_gesture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_info    (info),
        .i_cfg     (cfg),
        .o_gesture (gest)
    );

    // Assemble the result of the current transaction.
    assign result.event_valid = (gest.kind != KIND_NONE);
    assign result.kind        = gest.kind;
    assign result.clicks      = gest.clicks;
    assign result.button      = cfg.button;
    assign result.level       = info.level;
    assign result.action      = gest.action;

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_in_stall        = r_skid_valid;
    assign o_out_valid       = r_out_valid;
    assign o_event_valid     = r_out.event_valid;
    assign o_event_kind      = r_out.kind;
    assign o_clicks_reported = r_out.clicks;
    assign o_button_echo     = r_out.button;
    assign o_level_class     = r_out.level;
    assign o_action_now      = r_out.action;

endmodule

// ===== src/bclpd_checker.sv =====
// Port-level checks of the button detector and their bind to the top level.
module bclpd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_event_valid,
    input logic [2:0]                        o_event_kind,
    input logic [bclpd_pkg::CLICKS_W-1:0]    o_clicks_reported,
    input logic [1:0]                        o_level_class,
    input logic [1:0]                        o_action_now
);
    import bclpd_pkg::*;

    // A stalled result transaction holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_event_kind)
            && $stable(o_clicks_reported) && $stable(o_level_class)
            && $stable(o_action_now))
        else $error("result changed while stalled");

    // The event flag agrees with the event kind.
    a_event_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_valid == (o_event_kind != KIND_NONE)))
        else $error("event flag does not match event kind");

    // Click counts appear only with click events.
    a_clicks_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_event_kind == KIND_NONE) || (o_event_kind == KIND_LONG))
            |-> (o_clicks_reported == '0))
        else $error("click count without a click event");

    // The input stalls only behind a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output stage not empty after reset");

endmodule

bind button_click_long_press_detector bclpd_checker u_bclpd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_event_valid     (o_event_valid),
    .o_event_kind      (o_event_kind),
    .o_clicks_reported (o_clicks_reported),
    .o_level_class     (o_level_class),
    .o_action_now      (o_action_now)
);

// ===== tb/tb_button_click_long_press_detector.sv =====
// Self-checking testbench for the button debounce, click and long-press detector.
`timescale 1ns / 1ps

module tb_button_click_long_press_detector;
    import bclpd_pkg::*;

    localparam int          WIN_LEN        = 10;
    localparam int          OLD_LEN        = WIN_LEN / 2;
    localparam int          NEW_LEN        = WIN_LEN - OLD_LEN;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam int          RUN_LIMIT      = 50_000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          HOLDOFF_CYCLES = 60;
    localparam int          PHASE_SAMPLES  = 60;
    localparam int          SAT_PAIRS      = 262;
    localparam int          MAX_PRINTS     = 30;
    localparam int          DIR_ROWS       = 29;

    // Output expected right after reset while the window stays quiet.
    localparam t_result QUIET_RESET = '{1'b0, KIND_NONE, 8'd0, RST_BUTTON, CLASS_LOW, ACT_NONE};

    // One row of the directed table: a register write or a sample transaction.
    typedef struct packed {
        logic                  is_write;
        t_cfg_index            reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic                  pin;
        logic                  typed;
        t_result               want;
    } t_dir_row;

    // DUT ports.
    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = CFG_PRESS_LEVEL;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_stall;
    logic                   i_pin_level  = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall  = 1'b0;
    logic                   o_event_valid;
    logic [2:0]             o_event_kind;
    logic [CLICKS_W-1:0]    o_clicks_reported;
    logic [BUTTON_W-1:0]    o_button_echo;
    logic [1:0]             o_level_class;
    logic [1:0]             o_action_now;

    // Shadow of the configuration registers.
    logic                cfg_press  = RST_PRESS_LEVEL;
    logic [THRESH_W-1:0] cfg_long   = RST_LONG_TICKS;
    logic [THRESH_W-1:0] cfg_gap    = RST_GAP_TICKS;
    logic [BUTTON_W-1:0] cfg_button = RST_BUTTON;

    // Predicted debounce and gesture state.
    logic [WIN_LEN-1:0]  win_bits    = '0;
    t_level_class        win_class   = CLASS_LOW;
    logic                held        = 1'b0;
    logic                long_fired  = 1'b0;
    logic                gap_pending = 1'b0;
    logic [15:0]         hold_ticks  = '0;
    logic [15:0]         gap_ticks   = '0;
    logic [CLICKS_W-1:0] click_tally = '0;

    // Results still owed by the block, oldest first.
    t_result pending_events[$];

    // Run control and statistics.
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    bit          holdoff_req  = 1'b0;
    int          holdoff_left = 0;
    int unsigned cycle_count  = 0;
    int          error_count  = 0;
    int          samples_sent = 0;
    int          results_seen = 0;
    int          reg_writes   = 0;
    int          press_count  = 0;
    int          release_count = 0;
    int          stall_cycles = 0;
    int          kind_count [5] = '{0, 0, 0, 0, 0};
    t_dir_row    dir_rows [DIR_ROWS];

    button_click_long_press_detector u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pin_level       (i_pin_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_event_valid     (o_event_valid),
        .o_event_kind      (o_event_kind),
        .o_clicks_reported (o_clicks_reported),
        .o_button_echo     (o_button_echo),
        .o_level_class     (o_level_class),
        .o_action_now      (o_action_now)
    );

    // Free-running clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Cycle counter and run timeout.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results owed",
                     cycle_count, pending_events.size());
            $display("FAIL");
            $finish;
        end
    end

    // Prints one line per error, up to a cap, and counts every one.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("result %0d field %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
    endtask

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

    // Drops any click sequence in progress.
    function automatic void clear_clicks();
        click_tally = '0;
        hold_ticks  = '0;
        gap_ticks   = '0;
        long_fired  = 1'b0;
        gap_pending = 1'b0;
    endfunction

    // Shifts one sample into the window, classifies it and advances the gesture timing.
    function automatic t_result debounce_and_track(input logic pin);
        t_result      r;
        t_level_class prev;
        logic         older;
        logic         newer;
        logic         was_on;
        logic         is_on;
        logic         released_long;
        r             = '0;
        r.button      = cfg_button;
        prev          = win_class;
        released_long = 1'b0;

        win_bits = {pin == cfg_press, win_bits[WIN_LEN-1:1]};
        older = $countones(win_bits[OLD_LEN-1:0]) >= (OLD_LEN + 1) / 2;
        newer = $countones(win_bits[WIN_LEN-1:OLD_LEN]) >= (NEW_LEN + 1) / 2;
        if (older == newer)
            win_class = older ? CLASS_HIGH : CLASS_LOW;
        else
            win_class = older ? CLASS_FALL : CLASS_RISE;
        r.level = win_class;
        was_on  = (prev == CLASS_HIGH) || (prev == CLASS_RISE);
        is_on   = (win_class == CLASS_HIGH) || (win_class == CLASS_RISE);

        // Press and release transitions.
        if (!was_on && is_on) begin
            r.action    = ACT_PRESS;
            held        = 1'b1;
            hold_ticks  = '0;
            gap_ticks   = '0;
            long_fired  = 1'b0;
            gap_pending = 1'b0;
        end else if (was_on && !is_on && held) begin
            held = 1'b0;
            if (long_fired) begin
                // Letting go after a long press ends everything quietly.
                clear_clicks();
                released_long = 1'b1;
            end else begin
                r.action = ACT_RELEASE;
                if (click_tally != CLICKS_MAX)
                    click_tally++;
                hold_ticks  = '0;
                gap_ticks   = '0;
                gap_pending = 1'b1;
            end
        end

        // Hold timing and gap timing.
        if (!released_long && held) begin
            hold_ticks = sat_inc(hold_ticks);
            if (!long_fired && hold_ticks >= cfg_long) begin
                long_fired  = 1'b1;
                click_tally = '0;
                gap_ticks   = '0;
                gap_pending = 1'b0;
                r.kind      = KIND_LONG;
            end
        end else if (!released_long && gap_pending) begin
            gap_ticks = sat_inc(gap_ticks);
            if (gap_ticks >= cfg_gap) begin
                r.clicks = click_tally;
                if (click_tally == 8'd2)
                    r.kind = KIND_DOUBLE;
                else if (click_tally > 8'd2)
                    r.kind = KIND_MULTI;
                else
                    r.kind = KIND_CLICK;
                clear_clicks();
                r.action = ACT_NONE;
            end
        end
        r.event_valid = (r.kind != KIND_NONE);
        return r;
    endfunction

    // Checks one accepted result transaction against the oldest expectation.
    task automatic check_event();
        t_result want;
        if (pending_events.size() == 0) begin
            report_error("result transaction with no sample outstanding");
            return;
        end
        want = pending_events.pop_front();
        compare_field("event_valid", o_event_valid, want.event_valid);
        compare_field("event_kind", o_event_kind, want.kind);
        compare_field("clicks_reported", o_clicks_reported, want.clicks);
        compare_field("button_echo", o_button_echo, want.button);
        compare_field("level_class", o_level_class, want.level);
        compare_field("action_now", o_action_now, want.action);
        results_seen++;
    endtask

    // Result side: checks transactions and drives the stall, with one long hold-off on request.
    initial begin : event_sink
        forever begin
            @(posedge i_clk);
            if (i_in_valid && o_in_stall)
                stall_cycles++;
            if (o_out_valid && !i_out_stall)
                check_event();
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_stall <= 1'b1;
            end else if (holdoff_req) begin
                holdoff_req  = 1'b0;
                holdoff_left = HOLDOFF_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Offers one sample transaction and records what it must produce.
    task automatic offer_sample(input logic pin, input logic typed = 1'b0,
                                input t_result want = '0);
        t_result pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pin_level <= pin;
        do @(posedge i_clk); while (o_in_stall);
        pred = debounce_and_track(pin);
        pending_events.push_back(typed ? want : pred);
        samples_sent++;
        kind_count[int'(pred.kind)]++;
        if (pred.action == ACT_PRESS)
            press_count++;
        if (pred.action == ACT_RELEASE)
            release_count++;
    endtask

    // A run of one pin level, each sample flipped with the given chance.
    task automatic send_run(input logic pin, input int len, input int flip_pct);
        int n;
        for (n = 0; n < len; n++)
            offer_sample(($urandom_range(99) < flip_pct) ? ~pin : pin);
    endtask

    // Waits until every owed result has come back and the block has settled.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PRESS_LEVEL: cfg_press  = value[0];
            CFG_LONG_TICKS:  cfg_long   = value[THRESH_W-1:0];
            CFG_GAP_TICKS:   cfg_gap    = value[THRESH_W-1:0];
            CFG_BUTTON:      cfg_button = value[BUTTON_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Directed table row builders.
    function automatic t_dir_row sample_row(input logic pin);
        t_dir_row row;
        row     = '0;
        row.pin = pin;
        return row;
    endfunction

    function automatic t_dir_row typed_row(input logic pin, input t_result want);
        t_dir_row row;
        row       = sample_row(pin);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic t_dir_row write_row(input t_cfg_index idx,
                                           input logic [CFG_DATA_W-1:0] value);
        t_dir_row row;
        row           = '0;
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    // One gesture with random content: chatter, a long press, or a click sequence.
    task automatic send_gesture();
        int   choice;
        int   clicks;
        int   c;
        logic on;
        on     = cfg_press;
        choice = $urandom_range(9);
        if (choice < 2) begin
            send_run(1'($urandom_range(1)), $urandom_range(1, 12), 40);
        end else if (choice == 2) begin
            send_run(on, int'(cfg_long) + $urandom_range(4, 16), 3);
            send_run(~on, $urandom_range(8, 16), 3);
        end else begin
            clicks = $urandom_range(1, 4);
            for (c = 0; c < clicks; c++) begin
                send_run(on, $urandom_range(5, 12), 4);
                send_run(~on, $urandom_range(5, 10), 4);
            end
            send_run(~on, int'(cfg_gap) + $urandom_range(6, 12), 2);
        end
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct);
        int first;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        first       = samples_sent;
        while (samples_sent - first < PHASE_SAMPLES)
            send_gesture();
    endtask

    // Main stimulus sequence.
    initial begin : stimulus
        int row;
        int n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: quiet window after reset, then long press and a
        // one-tick gap that ends the click sequence on the release itself.
        dir_rows = '{
            typed_row(1'b0, QUIET_RESET), typed_row(1'b1, QUIET_RESET),
            typed_row(1'b0, QUIET_RESET), typed_row(1'b1, QUIET_RESET),
            write_row(CFG_PRESS_LEVEL, 16'd0), write_row(CFG_LONG_TICKS, 16'd1),
            write_row(CFG_GAP_TICKS, 16'd1), write_row(CFG_BUTTON, 16'd15),
            sample_row(1'b0), sample_row(1'b0), sample_row(1'b0), sample_row(1'b0),
            sample_row(1'b0), sample_row(1'b1), sample_row(1'b1), sample_row(1'b1),
            sample_row(1'b1), sample_row(1'b1),
            write_row(CFG_LONG_TICKS, 16'hFFFF),
            sample_row(1'b0), sample_row(1'b0), sample_row(1'b0), sample_row(1'b0),
            sample_row(1'b0), sample_row(1'b1), sample_row(1'b1), sample_row(1'b1),
            sample_row(1'b1), sample_row(1'b1)
        };
        tx_idle_pct = 9;
        rx_idle_pct = 70;
        for (row = 0; row < DIR_ROWS; row++) begin
            if (dir_rows[row].is_write)
                write_reg(dir_rows[row].reg_index, dir_rows[row].reg_value);
            else
                offer_sample(dir_rows[row].pin, dir_rows[row].typed, dir_rows[row].want);
        end

        // Random gestures under the three idling schemes.
        write_reg(CFG_PRESS_LEVEL, 16'd1);
        write_reg(CFG_LONG_TICKS, 16'($urandom_range(8, 20)));
        write_reg(CFG_GAP_TICKS, 16'($urandom_range(4, 12)));
        write_reg(CFG_BUTTON, 16'($urandom_range(1, 14)));
        random_phase(9, 70);

        write_reg(CFG_PRESS_LEVEL, 16'd0);
        write_reg(CFG_LONG_TICKS, 16'($urandom_range(6, 16)));
        write_reg(CFG_GAP_TICKS, 16'($urandom_range(2, 10)));
        write_reg(CFG_BUTTON, 16'd0);
        random_phase(70, 9);

        write_reg(CFG_PRESS_LEVEL, 16'($urandom_range(1)));
        write_reg(CFG_LONG_TICKS, 16'($urandom_range(10, 24)));
        write_reg(CFG_GAP_TICKS, 16'($urandom_range(4, 14)));
        holdoff_req = 1'b1;
        random_phase(0, 0);

        // Click count saturation: a pin that alternates every sample presses and
        // releases on every pair, giving more clicks than the tally can hold.
        write_reg(CFG_LONG_TICKS, 16'hFFFF);
        write_reg(CFG_GAP_TICKS, 16'd3);
        write_reg(CFG_BUTTON, 16'd15);
        for (n = 0; n < SAT_PAIRS; n++) begin
            offer_sample(cfg_press);
            offer_sample(~cfg_press);
        end
        send_run(~cfg_press, 12, 0);

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d samples and %0d results in %0d cycles, %0d register writes,",
                 samples_sent, results_seen, cycle_count, reg_writes);
        $display("%0d presses, %0d releases, events %0d/%0d/%0d/%0d, %0d input stall cycles",
                 press_count, release_count, kind_count[KIND_CLICK], kind_count[KIND_DOUBLE],
                 kind_count[KIND_MULTI], kind_count[KIND_LONG], stall_cycles);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/bclpd_pkg.sv
src/bclpd_cfg.sv
src/bclpd_window.sv
src/bclpd_gesture.sv
src/button_click_long_press_detector.sv
src/bclpd_checker.sv
tb/tb_button_click_long_press_detector.sv
